/* rtl/wmm_pkg.sv */
// shared constants and types for the windowed min/max filter
`default_nettype none

package wmm_pkg;

    // fixed width of the time, value, best value and data fields on the channels
    localparam int FIELD_WIDTH = 32;

    // default internal widths of time and value
    localparam int TIME_WIDTH_DEF  = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    // configuration register map
    localparam int CFG_INDEX_WIDTH = 8;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WINDOW_LENGTH = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TRACK_MAX     = CFG_INDEX_WIDTH'(1);

    // register reset values
    localparam logic [FIELD_WIDTH-1:0] WINDOW_LENGTH_RESET = FIELD_WIDTH'(1000);
    localparam logic                   TRACK_MAX_RESET     = 1'b0;

    // subwindow fractions as right shifts of the window length
    localparam int QUARTER_SHIFT = 2;
    localparam int HALF_SHIFT    = 1;

    // configuration as seen by the slot update
    typedef struct packed {
        logic [FIELD_WIDTH-1:0] window_length;
        logic                   track_max;
    } t_wmm_cfg;

endpackage

`default_nettype wire

/* rtl/wmm_ifs.sv */
// channel interfaces: sample input, result output and configuration writes
`default_nettype none

interface wmm_in_if import wmm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [FIELD_WIDTH-1:0] sample_time;
    logic [FIELD_WIDTH-1:0] sample_value;
    logic                   restart;

    modport source (output valid, output sample_time, output sample_value,
                    output restart, input ready);
    modport sink   (input valid, input sample_time, input sample_value,
                    input restart, output ready);
endinterface

interface wmm_out_if import wmm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [FIELD_WIDTH-1:0] best_value;

    modport source (output valid, output best_value, input ready);
    modport sink   (input valid, input best_value, output ready);
endinterface

interface wmm_cfg_if import wmm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [FIELD_WIDTH-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/wmm_cfg.sv */
// configuration registers: window length and min/max mode
`default_nettype none

module wmm_cfg import wmm_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    wmm_cfg_if.sink       i_cfg,
    output t_wmm_cfg      o_cfg
);

    logic [FIELD_WIDTH-1:0] r_window_length;
    logic                   r_track_max;

    // writes are always taken
    assign i_cfg.ready = 1'b1;

    // register file, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WINDOW_LENGTH_RESET;
            r_track_max     <= TRACK_MAX_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_WINDOW_LENGTH: r_window_length <= i_cfg.data;
                CFG_TRACK_MAX:     r_track_max     <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg.window_length = r_window_length;
    assign o_cfg.track_max     = r_track_max;

endmodule

`default_nettype wire

/* rtl/wmm_slots.sv */
// three candidate slots and their combinational update, registered on each step
`default_nettype none

module wmm_slots import wmm_pkg::*; #(
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_step,
    input  wire logic [TIME_WIDTH-1:0]  i_time,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    input  wire logic                   i_restart,
    input  wire t_wmm_cfg               i_cfg,
    output logic [VALUE_WIDTH-1:0]      o_best
);

    logic [TIME_WIDTH-1:0]  r_t [3];
    logic [VALUE_WIDTH-1:0] r_v [3];
    logic                   r_seeded;
    logic [TIME_WIDTH-1:0]  n_t [3];
    logic [VALUE_WIDTH-1:0] n_v [3];
    logic                   n_seed;

    // candidate slots after the later-slot improvement
    logic [TIME_WIDTH-1:0]  w_a1_t, w_a2_t;
    logic [VALUE_WIDTH-1:0] w_a1_v, w_a2_v;
    logic                   w_imp1, w_imp2;
    logic [TIME_WIDTH-1:0]  w_el0, w_el1, w_el2, w_el_a1;
    logic [FIELD_WIDTH-1:0] w_quarter, w_half;

    // a at least as good as b under the current mode
    function automatic logic as_good(input logic [VALUE_WIDTH-1:0] a,
                                     input logic [VALUE_WIDTH-1:0] b,
                                     input logic                   max_mode);
        return max_mode ? (a >= b) : (a <= b);
    endfunction

    // elapsed time beyond a limit, both widened to a common width
    function automatic logic beyond(input logic [TIME_WIDTH-1:0]  el,
                                    input logic [FIELD_WIDTH-1:0] lim);
        logic [TIME_WIDTH+FIELD_WIDTH-1:0] a;
        logic [TIME_WIDTH+FIELD_WIDTH-1:0] b;
        a = {{FIELD_WIDTH{1'b0}}, el};
        b = {{TIME_WIDTH{1'b0}}, lim};
        return a > b;
    endfunction

    // modular elapsed times against the stored slots
    assign w_el0 = i_time - r_t[0];
    assign w_el1 = i_time - r_t[1];
    assign w_el2 = i_time - r_t[2];

    assign w_quarter = i_cfg.window_length >> QUARTER_SHIFT;
    assign w_half    = i_cfg.window_length >> HALF_SHIFT;

    assign n_seed = i_restart || !r_seeded
                  || as_good(i_value, r_v[0], i_cfg.track_max)
                  || beyond(w_el2, i_cfg.window_length);

    // improvement of slots one and two
    assign w_imp1 = as_good(i_value, r_v[1], i_cfg.track_max);
    assign w_imp2 = as_good(i_value, r_v[2], i_cfg.track_max);

    always_comb begin
        w_a1_t  = r_t[1];
        w_a1_v  = r_v[1];
        w_a2_t  = r_t[2];
        w_a2_v  = r_v[2];
        w_el_a1 = w_el1;
        if (w_imp1) begin
            w_a1_t  = i_time;
            w_a1_v  = i_value;
            w_a2_t  = i_time;
            w_a2_v  = i_value;
            w_el_a1 = '0;
        end else if (w_imp2) begin
            w_a2_t = i_time;
            w_a2_v = i_value;
        end
    end

    // seeding, expiry shifts and subwindow refreshes
    always_comb begin
        n_t[0] = r_t[0];
        n_v[0] = r_v[0];
        n_t[1] = w_a1_t;
        n_v[1] = w_a1_v;
        n_t[2] = w_a2_t;
        n_v[2] = w_a2_v;
        if (n_seed) begin
            for (int k = 0; k < 3; k++) begin
                n_t[k] = i_time;
                n_v[k] = i_value;
            end
        end else if (beyond(w_el0, i_cfg.window_length)) begin
            if (beyond(w_el_a1, i_cfg.window_length)) begin
                // double shift: third slot moves to the front
                n_t[0] = w_a2_t;
                n_v[0] = w_a2_v;
                n_t[1] = i_time;
                n_v[1] = i_value;
            end else begin
                n_t[0] = w_a1_t;
                n_v[0] = w_a1_v;
                n_t[1] = w_a2_t;
                n_v[1] = w_a2_v;
            end
            n_t[2] = i_time;
            n_v[2] = i_value;
        end else if (w_a1_t == r_t[0] && beyond(w_el0, w_quarter)) begin
            n_t[1] = i_time;
            n_v[1] = i_value;
            n_t[2] = i_time;
            n_v[2] = i_value;
        end else if (w_a2_t == w_a1_t && beyond(w_el0, w_half)) begin
            n_t[2] = i_time;
            n_v[2] = i_value;
        end
    end

    assign o_best = n_v[0];

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            for (int k = 0; k < 3; k++) begin
                r_t[k] <= n_t[k];
                r_v[k] <= n_v[k];
            end
        end
    end

    // seeded flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded <= 1'b0;
        end else if (i_step) begin
            r_seeded <= 1'b1;
        end
    end

    a_seed_fills_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && n_seed) |=> (r_t[0] == r_t[1] && r_t[1] == r_t[2]
                                && r_v[0] == r_v[1] && r_v[1] == r_v[2]))
        else $error("seeding left slots unequal");

    a_restart_takes_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_restart) |=> (r_v[0] == $past(i_value) && r_t[0] == $past(i_time)))
        else $error("restart did not seed slot zero");

    a_seeded_after_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> r_seeded)
        else $error("seeded flag not set after a word");

endmodule

`default_nettype wire

/* rtl/windowed_min_max_filter.sv */
// Windowed min/max filter: running minimum or maximum over a sliding time
// window using three candidate slots. One result word per sample word. A
// word is registered on entry, the slot update runs combinationally between
// that input register and the result register, so a new word is taken
// every cycle while the result register is empty or its word is taken; a
// sample passes through the input register and then the result register.
// The input register takes one more word while a result is stalled.
// Configuration writes are taken at once and must only happen while idle.
`default_nettype none

module windowed_min_max_filter import wmm_pkg::*; #(
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    wmm_cfg_if.sink   i_cfg,
    wmm_in_if.sink    i_in,
    wmm_out_if.source o_out
);

    t_wmm_cfg               w_cfg;
    logic                   r_in_valid;
    logic [TIME_WIDTH-1:0]  r_in_time;
    logic [VALUE_WIDTH-1:0] r_in_value;
    logic                   r_in_restart;
    logic                   r_out_valid;
    logic [FIELD_WIDTH-1:0] r_out_best;
    logic                   w_advance;
    logic [VALUE_WIDTH-1:0] w_best;

    logic [TIME_WIDTH+FIELD_WIDTH-1:0]  w_time_ext;
    logic [VALUE_WIDTH+FIELD_WIDTH-1:0] w_value_ext;
    logic [VALUE_WIDTH+FIELD_WIDTH-1:0] w_best_ext;

    wmm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // word moves from input register into slots and result register
    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    // fit channel fields to internal widths
    assign w_time_ext  = {{TIME_WIDTH{1'b0}}, i_in.sample_time};
    assign w_value_ext = {{VALUE_WIDTH{1'b0}}, i_in.sample_value};
    assign w_best_ext  = {{FIELD_WIDTH{1'b0}}, w_best};

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_time    <= w_time_ext[TIME_WIDTH-1:0];
            r_in_value   <= w_value_ext[VALUE_WIDTH-1:0];
            r_in_restart <= i_in.restart;
        end
    end

    wmm_slots #(
        .TIME_WIDTH  (TIME_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_slots (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_advance),
        .i_time    (r_in_time),
        .i_value   (r_in_value),
        .i_restart (r_in_restart),
        .i_cfg     (w_cfg),
        .o_best    (w_best)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_best <= w_best_ext[FIELD_WIDTH-1:0];
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.best_value = r_out_best;

    a_advance_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("result register not loaded after a word moved");

    a_stalled_word_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_value)
                                        && $stable(r_in_time)))
        else $error("input word lost while the result side stalls");

    a_empty_stage_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_in.ready)
        else $error("empty input register refuses a word");

endmodule

`default_nettype wire
